[rtl/vpra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_pkg
// Types, constants and codes shared by the virtual page run allocator.
// ----------------------------------------------------------------------------
package vpra_pkg;

  localparam int unsigned MAX_PAGES_DEF = 4096;
  localparam logic [31:0] KERNEL_BASE_RST = 32'hc010_0000;
  localparam logic [31:0] USER_BASE_RST   = 32'h0000_0000;
  localparam logic [12:0] PAGES_RST       = 13'd4096;
  localparam logic [31:0] USER_LIMIT      = 32'hc000_0000 - 32'd4096;

  localparam logic [1:0] CFG_KERNEL_BASE  = 2'd0;
  localparam logic [1:0] CFG_USER_BASE    = 2'd1;
  localparam logic [1:0] CFG_KERNEL_PAGES = 2'd2;
  localparam logic [1:0] CFG_USER_PAGES   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic        pool_sel;
    logic [12:0] page_count;
    logic [31:0] free_addr;
  } vpra_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] run_addr;
  } vpra_out_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN, S_MARK, S_DONE
  } vpra_state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic scan_rd;
    logic scan_step;
    logic mark_step;
    logic finish;
  } vpra_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_early;
    logic is_alloc;
    logic scan_found;
    logic scan_refused;
    logic scan_end;
    logic mark_last;
  } vpra_sts_t;

endpackage

[rtl/vpra_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_ctrl
// Sequencer: clearing pass, request check, bit scan, run marking, result.
// ----------------------------------------------------------------------------
module vpra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vpra_pkg::vpra_sts_t sts,
  output vpra_pkg::vpra_cmd_t cmd
);
  import vpra_pkg::*;

  vpra_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.bad_early) state_nxt = S_DONE;
        else if (sts.is_alloc) state_nxt = S_SCAN_RD;
        else state_nxt = S_MARK;
      end
      S_SCAN_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_found && !sts.scan_refused) state_nxt = S_MARK;
        else if (sts.scan_found || sts.scan_end) state_nxt = S_DONE;
        else state_nxt = S_SCAN_RD;
      end
      S_MARK:    if (sts.mark_last) state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR:   cmd.clr_step  = 1'b1;
      S_IDLE:    cmd.load      = start;
      S_CHECK:   ;
      S_SCAN_RD: cmd.scan_rd   = 1'b1;
      S_SCAN:    cmd.scan_step = 1'b1;
      S_MARK:    cmd.mark_step = 1'b1;
      S_DONE:    cmd.finish    = 1'b1;
      default:   ;
    endcase
  end

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !busy) else $error("idle but busy");
  a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r == S_CHECK) else $error("start lost");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("done not followed by idle");
endmodule

[rtl/vpra_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpra_dp
// Datapath: config registers, bitmap memory, run search and mark/clear.
// ----------------------------------------------------------------------------
module vpra_dp #(
  parameter int unsigned MAX_PAGES = vpra_pkg::MAX_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  vpra_pkg::vpra_in_t  in_data,
  input  vpra_pkg::vpra_cmd_t cmd,
  output vpra_pkg::vpra_sts_t sts,
  output logic                out_valid,
  output vpra_pkg::vpra_out_t out_data
);
  import vpra_pkg::*;

  localparam int unsigned WORDS = (MAX_PAGES + 31) / 32;
  localparam int unsigned AW    = (2 * WORDS > 1) ? $clog2(2 * WORDS) : 1;
  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);

  logic [31:0] mem [2*WORDS];

  logic [31:0] kbase_r, ubase_r;
  logic [12:0] kpages_r, upages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r  <= KERNEL_BASE_RST;
      ubase_r  <= USER_BASE_RST;
      kpages_r <= PAGES_RST;
      upages_r <= PAGES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KERNEL_BASE:  kbase_r  <= cfg_data;
        CFG_USER_BASE:    ubase_r  <= cfg_data;
        CFG_KERNEL_PAGES: kpages_r <= cfg_data[12:0];
        CFG_USER_PAGES:   upages_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic        req_r, user_r;
  logic [PW:0] cnt_r, size_r;
  logic [31:0] base_r, addr_r;
  logic [PW:0] pos_r, run_r;
  logic [PW:0] end_r;
  logic [1:0]  status_r;
  logic [31:0] result_r;
  logic [AW:0] clr_r;
  logic [31:0] rd_r;
  logic        bad_r;

  logic [12:0] pages_sel;
  logic [31:0] base_sel, diff, start_addr;
  logic [19:0] idx_w;
  logic [PW:0] size_w;
  logic [PW:0] cnt_w;

  assign pages_sel = in_data.pool_sel ? upages_r : kpages_r;
  assign base_sel  = in_data.pool_sel ? ubase_r : kbase_r;
  assign size_w    = ({19'd0, pages_sel} > 32'(MAX_PAGES)) ? (PW+1)'(MAX_PAGES)
                                                           : (PW+1)'(pages_sel);
  assign cnt_w     = ((PW+1) > 13) ? (PW+1)'(in_data.page_count)
                                   : (PW+1)'(in_data.page_count);
  assign diff      = in_data.free_addr - base_sel;
  assign idx_w     = diff[31:12];

  logic bad_w, cnt_big;
  assign cnt_big = {19'd0, in_data.page_count} > 32'(MAX_PAGES);
  always_comb begin
    bad_w = (in_data.page_count == 13'd0);
    if (in_data.req_type) begin
      if ({12'd0, idx_w} >= 32'(size_w)) bad_w = 1'b1;
      else if (cnt_big) bad_w = 1'b1;
      else if (32'(cnt_w) > 32'(size_w) - {12'd0, idx_w}) bad_w = 1'b1;
    end
  end

  logic          bit_v;
  logic [AW-1:0] word_a;
  assign word_a = (user_r ? AW'(WORDS) : AW'(0)) + AW'(pos_r >> 5);
  assign bit_v  = rd_r[pos_r[4:0]];

  logic [PW:0] run_nxt;
  assign run_nxt = bit_v ? '0 : run_r + 1'b1;

  assign sts.clr_last     = (clr_r == (AW+1)'(2*WORDS - 1));
  assign sts.bad_early    = bad_r;
  assign sts.is_alloc     = !req_r;
  assign sts.scan_found   = !bit_v && (run_nxt == cnt_r);
  assign sts.scan_refused = user_r && (start_addr >= USER_LIMIT);
  assign sts.scan_end     = (pos_r + 1'b1 >= size_r);
  assign sts.mark_last    = mark_ph_r && (pos_r + 1'b1 == end_r);

  assign start_addr = base_r + {32'(pos_r + 1'b1 - cnt_r)} * 32'd4096;

  // read-modify-write: scan_rd reads, mark does rd/wr in two halves via rd_r
  logic mark_ph_r;
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_r[AW-1:0]] <= '0;
    if (cmd.scan_rd || (cmd.mark_step && !mark_ph_r)) rd_r <= mem[word_a];
    if (cmd.mark_step && mark_ph_r) begin
      if (req_r) mem[word_a] <= rd_r & ~(32'd1 << pos_r[4:0]);
      else       mem[word_a] <= rd_r |  (32'd1 << pos_r[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      out_valid <= 1'b0;
      mark_ph_r <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.load) mark_ph_r <= 1'b0;
      if (cmd.mark_step) mark_ph_r <= !mark_ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_data.req_type;
      user_r   <= in_data.pool_sel;
      cnt_r    <= cnt_big ? (PW+1)'(MAX_PAGES + 1) : cnt_w;
      size_r   <= size_w;
      base_r   <= base_sel;
      bad_r    <= bad_w || (!in_data.req_type && size_w == '0);
      pos_r    <= in_data.req_type ? (PW+1)'(idx_w) : '0;
      end_r    <= (PW+1)'(idx_w) + cnt_w;
      run_r    <= '0;
      status_r <= bad_w ? ST_BAD : ST_DONE;
      result_r <= '0;
      if (!in_data.req_type && !bad_w && size_w == '0) status_r <= ST_NOSPACE;
    end
    if (cmd.scan_rd && !req_r && size_r == '0) status_r <= ST_NOSPACE;
    if (cmd.scan_step) begin
      run_r <= run_nxt;
      if (sts.scan_found) begin
        if (sts.scan_refused) begin
          status_r <= ST_BAD;
        end else begin
          result_r <= start_addr;
          pos_r    <= pos_r + 1'b1 - cnt_r;
          end_r    <= pos_r + 1'b1;
        end
      end else if (sts.scan_end) begin
        status_r <= ST_NOSPACE;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
    if (cmd.mark_step && mark_ph_r) pos_r <= pos_r + 1'b1;
  end

  assign out_data.status   = status_r;
  assign out_data.run_addr = result_r;

  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_DONE) |-> out_data.run_addr == '0)
    else $error("refused item with address");
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> clr_r < (AW+1)'(2*WORDS)) else $error("clear overrun");
endmodule

[rtl/virtual_page_run_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_page_run_allocator
// First-fit page run allocator over kernel and user page bitmaps.
// ----------------------------------------------------------------------------
// Usage: drive in_data and pulse start while busy is low; the item is taken
// at that edge. One result per item appears on out_data with out_valid high
// for one cycle; the receiver cannot stall it.
// Config: cfg_valid/cfg_ready write register cfg_index (0 kernel_base,
// 1 user_base, 2 kernel_pages, 3 user_pages); write only while idle.
// Bad requests and allocations from an empty pool go from the check
// straight to the result. Allocate: one memory read and one test per bit
// for each page scanned, then a read and a write per page of the run marked.
// Free: a read-modify-write per page in the run on the single bitmap port.
// The bitmap memory port sets this pacing; one item at a time.
// Reset: after rst_n a clearing pass zeroes both bitmaps; busy is high
// during it.
// ----------------------------------------------------------------------------
module virtual_page_run_allocator #(
  parameter int unsigned MAX_PAGES = vpra_pkg::MAX_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vpra_pkg::vpra_in_t  in_data,
  output logic                out_valid,
  output vpra_pkg::vpra_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import vpra_pkg::*;

  vpra_cmd_t cmd;
  vpra_sts_t sts;

  assign cfg_ready = 1'b1;

  vpra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  vpra_dp #(.MAX_PAGES(MAX_PAGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_data(out_data)
  );
endmodule
